// ----- hdl/rbsd_pkg.sv -----
`timescale 1ns / 1ps

package rbsd_pkg;

    localparam int ID_W       = 16;
    localparam int ADDR_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int LEVELS     = 4;
    localparam int LEVEL_BITS = 4;
    localparam int MASK_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int CHANNELS   = 2;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(QUEUE_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic REG_BRIDGE_ADDR = 1'b0;
    localparam logic REG_LEVEL_MASK  = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               deflected;
        logic [ADDR_W-1:0]  dst;
        logic [ID_W-1:0]    id;
        logic               valid;
    } flit_t;

    localparam int FLIT_W  = $bits(flit_t);
    localparam int TDATA_W = ((2 * FLIT_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - 2 * FLIT_W;

    typedef struct packed {
        logic [ADDR_W-1:0] bridge_addr;
        logic [MASK_W-1:0] level_mask;
    } cfg_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } qstat_t;

    function automatic logic addr_match(input logic [ADDR_W-1:0] dst, input cfg_t cfg);
        logic hit;
        hit = 1'b1;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (!(l < MASK_W && cfg.level_mask[l]))
            begin
                if (dst[l*LEVEL_BITS +: LEVEL_BITS] != cfg.bridge_addr[l*LEVEL_BITS +: LEVEL_BITS])
                begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    function automatic flit_t deflect(input flit_t f);
        flit_t r;
        r = f;
        r.deflected = 1'b1;
        if (f.count != COUNT_MAX)
        begin
            r.count = f.count + COUNT_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- hdl/ring_bridge_swap_deflect_unit.sv -----
`timescale 1ns / 1ps

// One channel of a local/global ring bridge. Each input beat carries the flits
// arriving on both rings; each output beat carries the flits leaving on both
// rings. A new beat is accepted every cycle unless output back-pressure
// stalls the pipeline. The first stage decides swap, enqueue or deflect and
// issues the read of each bridge queue head; the registered RAM read data
// then fills the empty output slots as the output register loads. Each bridge
// queue is a small RAM with one write and one read port, so a push and a pop
// proceed in the same cycle. Output back-pressure stalls the pipeline without
// losing beats. Registers: bridge address at 0x0, level wildcard mask at 0x4.

module ring_bridge_swap_deflect_unit
    import rbsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // loc_valid, loc_id, loc_dst, loc_deflected, loc_count,
    // glb_valid, glb_id, glb_dst, glb_deflected, glb_count, zero pad
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // lout_valid, lout_id, lout_dst, lout_deflected, lout_count,
    // gout_valid, gout_id, gout_dst, gout_deflected, gout_count, zero pad
    output logic [TDATA_W-1:0]    m_axis_tdata
);

    cfg_t   cfg;
    qstat_t up_stat;
    qstat_t down_stat;
    flit_t  up_rd;
    flit_t  down_rd;

    flit_t  lf;
    flit_t  gf;
    flit_t  lo;
    flit_t  go;
    logic   accept;
    logic   l_up;
    logic   g_down;
    logic   swap;
    logic   up_push;
    logic   down_push;
    logic   up_pop;
    logic   down_pop;

    logic   s1_v_reg;
    flit_t  s1_lo_reg;
    flit_t  s1_go_reg;
    logic   s1_lfill_reg;
    logic   s1_gfill_reg;
    logic   s1_adv;

    logic   out_v_reg;
    flit_t  out_lo_reg;
    flit_t  out_go_reg;
    flit_t  lo_fin;
    flit_t  go_fin;

    rbsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbsd_queue u_up_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (up_push),
        .push_data (lf),
        .pop       (up_pop),
        .stat      (up_stat),
        .rd_data   (up_rd)
    );

    rbsd_queue u_down_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (down_push),
        .push_data (gf),
        .pop       (down_pop),
        .stat      (down_stat),
        .rd_data   (down_rd)
    );

    assign lf = s_axis_tdata[FLIT_W-1:0];
    assign gf = s_axis_tdata[2*FLIT_W-1:FLIT_W];

    assign s1_adv        = s1_v_reg && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = !s1_v_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign l_up   = lf.valid && !addr_match(lf.dst, cfg);
    assign g_down = gf.valid && addr_match(gf.dst, cfg);
    assign swap   = l_up && g_down;

    assign up_push   = accept && !swap && l_up && up_stat.not_full;
    assign down_push = accept && !swap && g_down && down_stat.not_full;

    always_comb
    begin
        lo = lf;
        go = gf;
        if (swap)
        begin
            lo = gf;
            go = lf;
        end
        else
        begin
            if (l_up)
            begin
                lo = up_stat.not_full ? '0 : deflect(lf);
            end
            if (g_down)
            begin
                go = down_stat.not_full ? '0 : deflect(gf);
            end
        end
        if (!lo.valid)
        begin
            lo = '0;
        end
        if (!go.valid)
        begin
            go = '0;
        end
    end

    assign down_pop = accept && !lo.valid && down_stat.not_empty;
    assign up_pop   = accept && !go.valid && up_stat.not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lo_reg    <= lo;
            s1_go_reg    <= go;
            s1_lfill_reg <= down_pop;
            s1_gfill_reg <= up_pop;
        end
    end

    assign lo_fin = s1_lfill_reg ? down_rd : s1_lo_reg;
    assign go_fin = s1_gfill_reg ? up_rd : s1_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_axis_tready)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_lo_reg <= lo_fin;
            out_go_reg <= go_fin;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_go_reg, out_lo_reg};

endmodule

// ----- hdl/rbsd_cfg.sv -----
`timescale 1ns / 1ps

module rbsd_cfg
    import rbsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_BRIDGE_ADDR: cfg_reg.bridge_addr <= pwdata[ADDR_W-1:0];
                REG_LEVEL_MASK:  cfg_reg.level_mask  <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_BRIDGE_ADDR: prdata[ADDR_W-1:0] = cfg_reg.bridge_addr;
            REG_LEVEL_MASK:  prdata[MASK_W-1:0] = cfg_reg.level_mask;
            default: ;
        endcase
    end

endmodule

// ----- hdl/rbsd_queue.sv -----
`timescale 1ns / 1ps

module rbsd_queue
    import rbsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  flit_t  push_data,
    input  logic   pop,
    output qstat_t stat,
    output flit_t  rd_data
);

    flit_t            mem [QUEUE_DEPTH];
    flit_t            rd_data_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign stat.not_full  = (occ_reg != OCC_FULL);
    assign stat.not_empty = (occ_reg != '0);
    assign rd_data        = rd_data_reg;

    always_comb
    begin
        occ_next = occ_reg;
        if (push && !pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (push)
            begin
                tail_reg <= (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ----- sim/bridge_route_checker.sv -----
`timescale 1ns / 1ps

module bridge_route_checker
    import rbsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // loc flit (valid, id, dst, deflected, count), glb flit, zero pad
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // lout flit (valid, id, dst, deflected, count), gout flit, zero pad
    input  logic [TDATA_W-1:0]    m_axis_tdata,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        flit_t gout;
        flit_t lout;
    } ring_pair_t;

    cfg_t       bridge_cfg = '0;
    flit_t      up_fifo[$];
    flit_t      down_fifo[$];
    ring_pair_t expected_q[$];
    int         err_count = 0;
    int         pending_cnt = 0;
    int         beat_no = 0;

    assign mismatches  = err_count;
    assign outstanding = pending_cnt;

    function automatic logic dst_below(input logic [ADDR_W-1:0] dst);
        logic hit;
        hit = 1'b1;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (!(l < MASK_W && bridge_cfg.level_mask[l]) &&
                dst[l*LEVEL_BITS +: LEVEL_BITS] != bridge_cfg.bridge_addr[l*LEVEL_BITS +: LEVEL_BITS])
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic flit_t mark_deflected(input flit_t f);
        flit_t r;
        r = f;
        r.deflected = 1'b1;
        if (f.count != 8'hFF)
        begin
            r.count = f.count + 8'd1;
        end
        return r;
    endfunction

    function automatic ring_pair_t route_beat(input flit_t lf, input flit_t gf);
        ring_pair_t r;
        flit_t      lo;
        flit_t      go;
        int         up_start;
        int         down_start;
        logic       l_up;
        logic       g_down;
        up_start   = up_fifo.size();
        down_start = down_fifo.size();
        l_up   = lf.valid && !dst_below(lf.dst);
        g_down = gf.valid && dst_below(gf.dst);
        lo = lf;
        go = gf;
        if (l_up && g_down)
        begin
            lo = gf;
            go = lf;
        end
        else
        begin
            if (l_up)
            begin
                if (up_start < QUEUE_DEPTH)
                begin
                    up_fifo.push_back(lf);
                    lo.valid = 1'b0;
                end
                else
                begin
                    lo = mark_deflected(lo);
                end
            end
            if (g_down)
            begin
                if (down_start < QUEUE_DEPTH)
                begin
                    down_fifo.push_back(gf);
                    go.valid = 1'b0;
                end
                else
                begin
                    go = mark_deflected(go);
                end
            end
        end
        // pop only entries present at the start of the beat
        if (!lo.valid && down_start > 0)
        begin
            lo = down_fifo.pop_front();
        end
        if (!go.valid && up_start > 0)
        begin
            go = up_fifo.pop_front();
        end
        if (!lo.valid)
        begin
            lo = '0;
        end
        if (!go.valid)
        begin
            go = '0;
        end
        r.lout = lo;
        r.gout = go;
        return r;
    endfunction

    function automatic logic flit_differs(input flit_t e, input flit_t a);
        return (e.valid != a.valid) || (e.id != a.id) || (e.dst != a.dst) ||
               (e.deflected != a.deflected) || (e.count != a.count);
    endfunction

    function automatic string flit_text(input flit_t f);
        return $sformatf("v=%0b id=%h dst=%h defl=%0b cnt=%h",
                         f.valid, f.id, f.dst, f.deflected, f.count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ring_pair_t got;
        ring_pair_t want;
        if (!rst_n)
        begin
            bridge_cfg = '0;
            up_fifo.delete();
            down_fifo.delete();
            expected_q.delete();
            pending_cnt <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[CFG_ADDR_W-1:2] == REG_BRIDGE_ADDR)
                begin
                    bridge_cfg.bridge_addr = pwdata[ADDR_W-1:0];
                end
                else if (paddr[CFG_ADDR_W-1:2] == REG_LEVEL_MASK)
                begin
                    bridge_cfg.level_mask = pwdata[MASK_W-1:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[2*FLIT_W-1:0];
                if (expected_q.size() == 0)
                begin
                    if (err_count < 10)
                    begin
                        $display("unexpected output beat: %s | %s",
                                 flit_text(got.lout), flit_text(got.gout));
                    end
                    err_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (flit_differs(want.lout, got.lout) || flit_differs(want.gout, got.gout))
                    begin
                        if (err_count < 10)
                        begin
                            $display("beat %0d mismatch", beat_no);
                            $display("  expected lout %s | gout %s",
                                     flit_text(want.lout), flit_text(want.gout));
                            $display("  actual   lout %s | gout %s",
                                     flit_text(got.lout), flit_text(got.gout));
                        end
                        err_count++;
                    end
                end
                beat_no++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_q.push_back(route_beat(s_axis_tdata[FLIT_W-1:0],
                                                s_axis_tdata[2*FLIT_W-1:FLIT_W]));
            end
            pending_cnt <= expected_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rbsd_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] BRIDGE_ADDR_OFS = {REG_BRIDGE_ADDR, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] LEVEL_MASK_OFS  = {REG_LEVEL_MASK, 2'b00};
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;

    int                    mismatches;
    int                    outstanding;
    int                    gap_pct;
    int                    stall_pct;
    int                    hold_ask;
    int                    quiet_cycles;
    logic [ADDR_W-1:0]     addr_sel;
    logic [MASK_W-1:0]     mask_sel;

    ring_bridge_swap_deflect_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bridge_route_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #2 clk = ~clk;

    function automatic flit_t flit(input logic v, input logic [ID_W-1:0] id,
                                   input logic [ADDR_W-1:0] dst, input logic defl,
                                   input logic [COUNT_W-1:0] cnt);
        flit_t f;
        f.valid     = v;
        f.id        = id;
        f.dst       = dst;
        f.deflected = defl;
        f.count     = cnt;
        return f;
    endfunction

    function automatic flit_t make_flit(input logic v, input logic to_bridge);
        flit_t f;
        int    pick;
        f.valid     = v;
        f.id        = ID_W'($urandom);
        f.dst       = ADDR_W'($urandom);
        f.deflected = 1'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            f.count = 8'hFF;
        end
        else if (pick == 1)
        begin
            f.count = 8'hFE;
        end
        else
        begin
            f.count = COUNT_W'($urandom);
        end
        if (to_bridge)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                if (!mask_sel[l])
                begin
                    f.dst[l*LEVEL_BITS +: LEVEL_BITS] = addr_sel[l*LEVEL_BITS +: LEVEL_BITS];
                end
            end
        end
        return f;
    endfunction

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_bridge(input logic [ADDR_W-1:0] a, input logic [MASK_W-1:0] m);
        addr_sel = a;
        mask_sel = m;
        cfg_write(BRIDGE_ADDR_OFS, CFG_DATA_W'(a));
        cfg_write(LEVEL_MASK_OFS, CFG_DATA_W'(m));
    endtask

    task automatic offer(input flit_t l, input flit_t g);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({g, l});
        do @(posedge clk); while (!s_axis_tready);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic offer_random();
        offer(make_flit($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 30),
              make_flit($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 50));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** ring_bridge_swap_deflect_unit: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] a;
        logic [MASK_W-1:0] m;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        gap_pct       = 20;
        stall_pct     = 20;
        hold_ask      = 0;
        addr_sel      = '0;
        mask_sel      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_bridge(16'h5A3C, 4'h0);
        // noise only, then one flit heading up, then a direct swap
        offer(flit(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF),
              flit(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF));
        offer(flit(1'b1, 16'h0001, 16'hFFFF, 1'b0, 8'h00),
              flit(1'b0, 16'h0000, 16'h0000, 1'b0, 8'h00));
        offer(flit(1'b1, 16'hFFFF, 16'h0000, 1'b1, 8'hFF),
              flit(1'b1, 16'h0000, 16'h5A3C, 1'b0, 8'h00));
        // fill the up queue while the global ring stays busy, then deflect up to saturation
        for (int i = 0; i < 6; i++)
        begin
            offer(flit(1'b1, ID_W'(16'h0100 + i), 16'hFFFF, 1'b0, (i < 3) ? 8'hFE : 8'hFF),
                  flit(1'b1, ID_W'(16'h0200 + i), 16'h0000, 1'b0, 8'h00));
        end
        // fill the down queue while the local ring stays busy
        for (int i = 0; i < 6; i++)
        begin
            offer(flit(1'b1, ID_W'(16'h0300 + i), 16'h5A3C, 1'b1, 8'h7F),
                  flit(1'b1, ID_W'(16'h0400 + i), 16'h5A3C, 1'b0, (i < 4) ? 8'hFE : 8'hFF));
        end
        for (int i = 0; i < 4; i++)
        begin
            offer(flit(1'b0, 16'h0000, 16'h0000, 1'b0, 8'h00),
                  flit(1'b0, 16'h0000, 16'h0000, 1'b0, 8'h00));
        end
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin a = 16'h0000; m = 4'h0; end
                1: begin a = 16'hFFFF; m = 4'hF; end
                2: begin a = ADDR_W'($urandom); m = 4'h1; end
                3: begin a = ADDR_W'($urandom); m = 4'h2; end
                4: begin a = ADDR_W'($urandom); m = 4'h4; end
                5: begin a = ADDR_W'($urandom); m = 4'h8; end
                default: begin a = ADDR_W'($urandom); m = MASK_W'($urandom); end
            endcase
            repeat (4) @(posedge clk);
            set_bridge(a, m);
            if (p == 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
                hold_ask  = hold_ask + 1;
            end
            else if (p == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = (p == 3) ? 0 : $urandom_range(0, 2) * 15;
                stall_pct = $urandom_range(0, 2) * 15;
            end
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (p == 2 && i == PHASE_BEATS / 2)
                begin
                    drain();
                end
                offer_random();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("** ring_bridge_swap_deflect_unit: PASSED **");
        end
        else
        begin
            $display("** ring_bridge_swap_deflect_unit: FAILED **");
        end
        $finish;
    end

endmodule
